// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk_s, rst_n_s, expr_s, msg_s) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (expr_s)) \
		else $error(msg_s);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk_s, rst_n_s, ante_s, cons_s, msg_s) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante_s) |-> (cons_s)) \
		else $error(msg_s);

`else

`define ASSERT_ALWAYS(lbl, clk_s, rst_n_s, expr_s, msg_s)
`define ASSERT_IMPLIES(lbl, clk_s, rst_n_s, ante_s, cons_s, msg_s)

`endif

`endif

// ----- sv/ctst_pkg.sv -----
// ----------------------------------------------------------------------------
// ctst_pkg
// types, codes and slot update functions of the task scheduler table
// ----------------------------------------------------------------------------
package ctst_pkg;

	// request operations
	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_DELETE   = 2'd1,
		OP_TICK     = 2'd2,
		OP_DISPATCH = 2'd3
	} op_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_ADDED     = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_DELETED   = 3'd2,
		KIND_EMPTY     = 3'd3,
		KIND_TICK_DONE = 3'd4,
		KIND_RUN       = 3'd5,
		KIND_NONE_DUE  = 3'd6
	} kind_t;

	localparam logic [7:0] PEND_MAX     = 8'd255;
	localparam int         RESULT_LIMIT = 16;
	localparam int         RES_CNT_W    = 5;

	// one slot as held in the slot memory
	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] countdown;
		logic [31:0] period;
		logic [7:0]  pending;
	} entry_t;

	// one tick applied to an occupied slot
	function automatic entry_t tick_entry(input entry_t e);
		entry_t r;
		r = e;
		if (e.countdown == 32'd0) begin
			if (e.pending != PEND_MAX) begin
				r.pending = e.pending + 8'd1;
			end
			if (e.period != 32'd0) begin
				r.countdown = e.period;
			end
		end else begin
			r.countdown = e.countdown - 32'd1;
		end
		return r;
	endfunction

	// one run taken from a due slot
	function automatic entry_t dispatch_entry(input entry_t e);
		entry_t r;
		r = e;
		r.pending = e.pending - 8'd1;
		return r;
	endfunction

endpackage

// ----- sv/ctst_slot_ram.sv -----
// ----------------------------------------------------------------------------
// ctst_slot_ram
// slot memory, one write and one registered read port
// ----------------------------------------------------------------------------
module ctst_slot_ram #(
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [ADDR_W-1:0]     rd_addr,
	output ctst_pkg::entry_t      rd_data,
	input  logic                  wr_en,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  ctst_pkg::entry_t      wr_data
);

	ctst_pkg::entry_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- sv/cooperative_task_scheduler_table.sv -----
// ----------------------------------------------------------------------------
// cooperative_task_scheduler_table: slot table with tick and dispatch scans
// add, delete, dispatch with nothing due: exec state decides, result state emits the result
// tick: every slot read in turn and written back if occupied, then a tick done result
// dispatch: slots scanned up to the last due one, one run each, at most RESULT_LIMIT runs
// one request at a time, the next accepted the cycle after the last result is loaded
// reset clears occupied marks and control at once; the slot memory needs no clear
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cooperative_task_scheduler_table #(
	parameter int MAX_TASKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  slot,
	input  logic [15:0] task_tag,
	input  logic [31:0] delay,
	input  logic [31:0] period,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [3:0]  slot_index,
	output logic [15:0] run_tag,
	output logic        last
);

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TICK,
		ST_DSCAN,
		ST_DMOD,
		ST_RESULT
	} state_t;

	// low four bits of a slot number
	function automatic logic [3:0] slot4(input logic [IDX_W-1:0] ix);
		logic [IDX_W+3:0] w;
		w = {4'b0000, ix};
		return w[3:0];
	endfunction

	state_t                          state_q;
	ctst_pkg::op_t                   req_op_q;
	logic [3:0]                      req_slot_q;
	logic [15:0]                     req_tag_q;
	logic [31:0]                     req_delay_q;
	logic [31:0]                     req_period_q;
	logic [MAX_TASKS-1:0]            occ_q;
	logic [MAX_TASKS-1:0]            nz_q;
	logic [CNT_W-1:0]                i_q;
	logic [ctst_pkg::RES_CNT_W-1:0]  cnt_q;
	logic                            tick_v_s1;
	logic [IDX_W-1:0]                idx_s1;
	ctst_pkg::kind_t                 res_kind_q;
	logic [3:0]                      res_slot_q;
	logic                            out_valid_q;
	ctst_pkg::kind_t                 kind_q;
	logic [3:0]                      slot_index_q;
	logic [15:0]                     run_tag_q;
	logic                            last_q;

	logic [IDX_W-1:0]     idx;
	logic [MAX_TASKS-1:0] due_vec;
	logic                 more_above;
	logic                 out_free;
	logic                 scan_live;
	logic                 dmod_last;
	logic                 free_found;
	logic [IDX_W-1:0]     free_idx;
	logic                 slot_oor;
	logic [IDX_W+3:0]     slot_w;
	logic [IDX_W-1:0]     slot_idx;

	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	ctst_pkg::entry_t     rd_data;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	ctst_pkg::entry_t     wr_data;

	logic                 emit;
	ctst_pkg::kind_t      emit_kind;
	logic [3:0]           emit_slot;
	logic [15:0]          emit_tag;
	logic                 emit_last;

	// scan position and due slots
	assign idx        = i_q[IDX_W-1:0];
	assign scan_live  = i_q < CNT_W'(MAX_TASKS);
	assign due_vec    = occ_q & nz_q;
	assign more_above = ((due_vec >> idx) >> 1) != '0;
	assign dmod_last  = (cnt_q == ctst_pkg::RES_CNT_W'(ctst_pkg::RESULT_LIMIT - 1))
		|| !more_above;
	assign out_free   = !out_valid_q || out_ready;

	// delete target
	assign slot_w   = {{IDX_W{1'b0}}, req_slot_q};
	assign slot_idx = slot_w[IDX_W-1:0];
	assign slot_oor = int'(req_slot_q) >= MAX_TASKS;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = MAX_TASKS - 1; k >= 0; k--) begin
			if (!occ_q[k]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(k);
			end
		end
	end

	// memory drives and result emission
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = idx;
		wr_en     = 1'b0;
		wr_addr   = idx;
		wr_data   = rd_data;
		emit      = 1'b0;
		emit_kind = ctst_pkg::KIND_NONE_DUE;
		emit_slot = 4'd0;
		emit_tag  = 16'd0;
		emit_last = 1'b1;
		unique case (state_q)
			ST_EXEC: begin
				if (req_op_q == ctst_pkg::OP_ADD && free_found) begin
					wr_en           = 1'b1;
					wr_addr         = free_idx;
					wr_data.tag       = req_tag_q;
					wr_data.countdown = req_delay_q;
					wr_data.period    = req_period_q;
					wr_data.pending   = 8'd0;
				end
			end
			ST_TICK: begin
				rd_en = scan_live;
				if (tick_v_s1 && occ_q[idx_s1]) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1;
					wr_data = ctst_pkg::tick_entry(rd_data);
				end
			end
			ST_DSCAN: begin
				rd_en = scan_live && due_vec[idx];
			end
			ST_DMOD: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = ctst_pkg::KIND_RUN;
					emit_slot = slot4(idx);
					emit_tag  = rd_data.tag;
					emit_last = dmod_last;
					wr_en     = 1'b1;
					wr_data   = ctst_pkg::dispatch_entry(rd_data);
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = res_kind_q;
					emit_slot = res_slot_q;
				end
			end
			default: begin
			end
		endcase
	end

	ctst_slot_ram #(
		.DEPTH(MAX_TASKS)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// request payload capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_op_q     <= ctst_pkg::op_t'(op);
			req_slot_q   <= slot;
			req_tag_q    <= task_tag;
			req_delay_q  <= delay;
			req_period_q <= period;
		end
	end

	// sequencer, occupied and due marks, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			occ_q        <= '0;
			nz_q         <= '0;
			i_q          <= '0;
			cnt_q        <= '0;
			tick_v_s1    <= 1'b0;
			idx_s1       <= '0;
			res_kind_q   <= ctst_pkg::KIND_NONE_DUE;
			res_slot_q   <= 4'd0;
			out_valid_q  <= 1'b0;
			kind_q       <= ctst_pkg::KIND_NONE_DUE;
			slot_index_q <= 4'd0;
			run_tag_q    <= 16'd0;
			last_q       <= 1'b0;
		end else begin
			// output register
			if (emit) begin
				out_valid_q  <= 1'b1;
				kind_q       <= emit_kind;
				slot_index_q <= emit_slot;
				run_tag_q    <= emit_tag;
				last_q       <= emit_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// tick write-back sets the due mark on expiry
			if (state_q == ST_TICK && tick_v_s1 && occ_q[idx_s1]
				&& rd_data.countdown == 32'd0) begin
				nz_q[idx_s1] <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (req_op_q)
						ctst_pkg::OP_ADD: begin
							if (free_found) begin
								occ_q[free_idx] <= 1'b1;
								nz_q[free_idx]  <= 1'b0;
								res_kind_q      <= ctst_pkg::KIND_ADDED;
								res_slot_q      <= slot4(free_idx);
							end else begin
								res_kind_q <= ctst_pkg::KIND_FULL;
								res_slot_q <= 4'd0;
							end
							state_q <= ST_RESULT;
						end
						ctst_pkg::OP_DELETE: begin
							res_slot_q <= req_slot_q;
							if (slot_oor) begin
								res_kind_q <= ctst_pkg::KIND_EMPTY;
							end else begin
								res_kind_q <= occ_q[slot_idx] ? ctst_pkg::KIND_DELETED
									: ctst_pkg::KIND_EMPTY;
								occ_q[slot_idx] <= 1'b0;
								nz_q[slot_idx]  <= 1'b0;
							end
							state_q <= ST_RESULT;
						end
						ctst_pkg::OP_TICK: begin
							i_q     <= '0;
							state_q <= ST_TICK;
						end
						ctst_pkg::OP_DISPATCH: begin
							i_q   <= '0;
							cnt_q <= '0;
							if (due_vec == '0) begin
								res_kind_q <= ctst_pkg::KIND_NONE_DUE;
								res_slot_q <= 4'd0;
								state_q    <= ST_RESULT;
							end else begin
								state_q <= ST_DSCAN;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_TICK: begin
					// read slot i while writing back slot i-1
					if (scan_live) begin
						tick_v_s1 <= 1'b1;
						idx_s1    <= idx;
						i_q       <= i_q + CNT_W'(1);
					end else begin
						tick_v_s1  <= 1'b0;
						res_kind_q <= ctst_pkg::KIND_TICK_DONE;
						res_slot_q <= 4'd0;
						state_q    <= ST_RESULT;
					end
				end
				ST_DSCAN: begin
					if (!scan_live) begin
						state_q <= ST_IDLE;
					end else if (due_vec[idx]) begin
						state_q <= ST_DMOD;
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				ST_DMOD: begin
					if (out_free) begin
						i_q   <= i_q + CNT_W'(1);
						cnt_q <= cnt_q + ctst_pkg::RES_CNT_W'(1);
						if (rd_data.period == 32'd0) begin
							occ_q[idx] <= 1'b0;
							nz_q[idx]  <= 1'b0;
						end else begin
							nz_q[idx] <= rd_data.pending != 8'd1;
						end
						state_q <= dmod_last ? ST_IDLE : ST_DSCAN;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = state_q == ST_IDLE;
	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign slot_index = slot_index_q;
	assign run_tag    = run_tag_q;
	assign last       = last_q;

	// checks
	`ASSERT_IMPLIES(a_emit_room, clk, arst_n, emit, out_free, "result emitted over a held one")
	`ASSERT_ALWAYS(a_due_occ, clk, arst_n, (nz_q & ~occ_q) == '0, "pending mark on a free slot")
	`ASSERT_IMPLIES(a_run_due, clk, arst_n, state_q == ST_DMOD && emit, due_vec[idx],
		"run issued for a slot that is not due")
	`ASSERT_IMPLIES(a_tick_drain, clk, arst_n, in_ready, !tick_v_s1,
		"tick write-back still in flight at idle")

endmodule
